// ===== hw/rtl/zx0_pkg.sv =====
// Package for the ZX0 stream decompressor: sizes, opcodes, phases and the
// command/status structs between controller and datapath. No dependencies.
package zx0_pkg;

    localparam int OUTPUT_DEPTH = 16384;
    localparam int AW = $clog2(OUTPUT_DEPTH);
    localparam int CW = AW + 1;

    localparam logic [1:0] OP_FEED    = 2'd0;
    localparam logic [1:0] OP_ADVANCE = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_DONE = 2'd1;
    localparam logic [1:0] ST_ERR  = 2'd2;

    localparam logic [3:0] PH_LIT_LEN     = 4'd0;
    localparam logic [3:0] PH_LITERALS    = 4'd1;
    localparam logic [3:0] PH_AFTER_LIT   = 4'd2;
    localparam logic [3:0] PH_LAST_LEN    = 4'd3;
    localparam logic [3:0] PH_OFS_HIGH    = 4'd4;
    localparam logic [3:0] PH_OFS_LOW     = 4'd5;
    localparam logic [3:0] PH_MATCH_LEN   = 4'd6;
    localparam logic [3:0] PH_AFTER_MATCH = 4'd7;
    localparam logic [3:0] PH_COPY        = 4'd8;
    localparam logic [3:0] PH_DONE        = 4'd9;
    localparam logic [3:0] PH_BAD         = 4'd10;

    typedef struct packed {
        logic       start;      // take a new item into the datapath
        logic [1:0] op;
        logic [7:0] data;
        logic       step;       // perform one decode step
        logic       finish;     // capture the result word
    } cmd_t;

    typedef struct packed {
        logic again;            // the decode step wants another pass
        logic read_wait;        // a history read is in flight
    } stat_t;

endpackage

// ===== hw/rtl/zx0_if.sv =====
// Valid/ready stream interfaces for the ZX0 decompressor channels.
// Depends on nothing.
interface zx0_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] data_byte;
    modport source (output valid, opcode, data_byte, input ready);
    modport sink (input valid, opcode, data_byte, output ready);
endinterface

interface zx0_out_if;
    logic        valid;
    logic        ready;
    logic        out_valid;
    logic [13:0] out_addr;
    logic [7:0]  out_data;
    logic        need_byte;
    logic [1:0]  status;
    modport source (output valid, out_valid, out_addr, out_data, need_byte, status,
                    input ready);
    modport sink (input valid, out_valid, out_addr, out_data, need_byte, status,
                  output ready);
endinterface

interface zx0_cfg_if;
    logic        valid;
    logic        ready;
    logic [14:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ===== hw/rtl/zx0_ram.sv =====
// Generic single-port RAM with registered read.
// Depends on nothing.
module zx0_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== hw/rtl/zx0_datapath.sv =====
// Datapath of the ZX0 decompressor: decoder state, one decode step per
// command, history RAM and result register. Depends on zx0_pkg, zx0_ram.
module zx0_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  zx0_pkg::cmd_t      cmd,
    output zx0_pkg::stat_t     stat,
    input  logic               cfg_we,
    input  logic [14:0]        cfg_data,
    output logic               res_out_valid,
    output logic [13:0]        res_out_addr,
    output logic [7:0]         res_out_data,
    output logic               res_need_byte,
    output logic [1:0]         res_status
);
    localparam int AW = zx0_pkg::AW;
    localparam int CW = zx0_pkg::CW;
    localparam logic [CW-1:0] DEPTH_C = CW'(zx0_pkg::OUTPUT_DEPTH);

    logic [14:0]   capacity_reg;
    logic [CW-1:0] wc_reg, wc_next;
    logic [14:0]   lit_reg, lit_next;
    logic [14:0]   cop_reg, cop_next;
    logic [14:0]   ofs_reg, ofs_next;
    logic [14:0]   gam_reg, gam_next;
    logic          ctl_reg, ctl_next;
    logic [7:0]    bb_reg, bb_next;
    logic [7:0]    bm_reg, bm_next;
    logic [3:0]    ph_reg, ph_next;
    logic          have_reg, have_next;
    logic          act_reg, act_next;
    logic [7:0]    b_reg;
    logic          emit_reg, emit_next;
    logic [AW-1:0] eaddr_reg, eaddr_next;
    logic [7:0]    edata_reg, edata_next;
    logic          rd_reg, rd_next;
    logic          again;

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [7:0]    ram_wdata, ram_rdata;

    logic [15:0]   cap_now, room;
    logic          waiting;

    assign cap_now = ({1'b0, capacity_reg} > 16'(DEPTH_C)) ? 16'(DEPTH_C)
                                                            : {1'b0, capacity_reg};
    assign room = (16'(wc_reg) >= cap_now) ? 16'd0 : cap_now - 16'(wc_reg);
    assign waiting = !(ph_reg == zx0_pkg::PH_DONE || ph_reg == zx0_pkg::PH_BAD ||
                       ph_reg == zx0_pkg::PH_COPY) &&
                     (ph_reg == zx0_pkg::PH_LITERALS || ph_reg == zx0_pkg::PH_OFS_LOW ||
                      bm_reg == 8'd0);

    zx0_ram #(.WIDTH(8), .DEPTH(zx0_pkg::OUTPUT_DEPTH)) u_hist (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata));

    always_comb
    begin
        logic [15:0] len;
        logic [15:0] nxt;
        logic [15:0] src;
        logic        bit_v;
        logic        high;
        logic [7:0]  bm;
        wc_next = wc_reg; lit_next = lit_reg; cop_next = cop_reg; ofs_next = ofs_reg;
        gam_next = gam_reg; ctl_next = ctl_reg; bb_next = bb_reg; bm_next = bm_reg;
        ph_next = ph_reg; have_next = have_reg; emit_next = emit_reg;
        act_next = act_reg;
        eaddr_next = eaddr_reg; edata_next = edata_reg; rd_next = 1'b0;
        again = 1'b0; ram_we = 1'b0; ram_addr = wc_reg[AW-1:0]; ram_wdata = b_reg;
        len = 16'd0; nxt = 16'd0; bit_v = 1'b0; high = 1'b0; bm = bm_reg;
        src = 16'(wc_reg) - {1'b0, ofs_reg};
        if (ph_reg == zx0_pkg::PH_COPY && !rd_reg)
        begin
            ram_addr = src[AW-1:0];
        end
        // Only an advance, or a feed that the decoder was waiting for, runs
        // decode steps; other words run none (a restart resets the decoder and a feed after the end sets the error).
        if (cmd.step && act_reg)
        begin
            if (ph_reg == zx0_pkg::PH_DONE || ph_reg == zx0_pkg::PH_BAD)
            begin
                again = 1'b0;
            end
            else if (ph_reg == zx0_pkg::PH_COPY)
            begin
                if (ofs_reg == 15'd0 || 16'(ofs_reg) > 16'(wc_reg) ||
                    src >= 16'(DEPTH_C))
                begin
                    ph_next = zx0_pkg::PH_BAD;
                end
                else if (!rd_reg)
                begin
                    rd_next = 1'b1;
                    again = 1'b1;
                end
                else if (wc_reg >= DEPTH_C)
                begin
                    ph_next = zx0_pkg::PH_BAD;
                end
                else
                begin
                    ram_we = 1'b1; ram_wdata = ram_rdata;
                    emit_next = 1'b1; eaddr_next = wc_reg[AW-1:0];
                    edata_next = ram_rdata; wc_next = wc_reg + 1'b1;
                    cop_next = cop_reg - 1'b1;
                    if (cop_reg == 15'd1)
                    begin
                        ph_next = zx0_pkg::PH_AFTER_MATCH;
                    end
                end
            end
            else if (ph_reg == zx0_pkg::PH_LITERALS || ph_reg == zx0_pkg::PH_OFS_LOW)
            begin
                if (have_reg)
                begin
                    have_next = 1'b0;
                    if (ph_reg == zx0_pkg::PH_LITERALS)
                    begin
                        if (wc_reg >= DEPTH_C)
                        begin
                            ph_next = zx0_pkg::PH_BAD;
                        end
                        else
                        begin
                            ram_we = 1'b1; emit_next = 1'b1;
                            eaddr_next = wc_reg[AW-1:0]; edata_next = b_reg;
                            wc_next = wc_reg + 1'b1;
                            if (lit_reg <= 15'd1)
                            begin
                                lit_next = 15'd0; ph_next = zx0_pkg::PH_AFTER_LIT;
                            end
                            else
                            begin
                                lit_next = lit_reg - 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        ofs_next = 15'({gam_reg[7:0], 7'd0} - {8'd0, b_reg[7:1]});
                        gam_next = 15'd1; ctl_next = 1'b1;
                        ph_next = zx0_pkg::PH_MATCH_LEN;
                        again = 1'b1;
                        if (b_reg[0])
                        begin
                            if (ofs_next == 15'd0 || 16'(ofs_next) > 16'(wc_reg) ||
                                room < 16'd2)
                            begin
                                ph_next = zx0_pkg::PH_BAD;
                            end
                            else
                            begin
                                cop_next = 15'd2; ph_next = zx0_pkg::PH_COPY;
                            end
                        end
                        else
                        begin
                            ctl_next = 1'b0;
                        end
                    end
                end
            end
            else if (bm_reg == 8'd0 && !have_reg)
            begin
                again = 1'b0;
            end
            else
            begin
                if (bm_reg == 8'd0)
                begin
                    have_next = 1'b0; bb_next = b_reg; bm = 8'h80;
                end
                bit_v = ((bm_reg == 8'd0 ? b_reg : bb_reg) & bm) != 8'd0;
                high = ph_reg == zx0_pkg::PH_OFS_HIGH;
                bm_next = bm >> 1;
                again = 1'b1;
                if (ph_reg == zx0_pkg::PH_AFTER_LIT || ph_reg == zx0_pkg::PH_AFTER_MATCH)
                begin
                    gam_next = 15'd1; ctl_next = 1'b1;
                    ph_next = bit_v ? zx0_pkg::PH_OFS_HIGH :
                              (ph_reg == zx0_pkg::PH_AFTER_LIT ? zx0_pkg::PH_LAST_LEN
                                                               : zx0_pkg::PH_LIT_LEN);
                end
                else if (!ctl_reg)
                begin
                    nxt = {gam_reg, bit_v ^ high};
                    if (nxt > (high ? 16'd256 : cap_now))
                    begin
                        ph_next = zx0_pkg::PH_BAD; again = 1'b0;
                    end
                    else
                    begin
                        gam_next = nxt[14:0]; ctl_next = 1'b1;
                    end
                end
                else if (!bit_v)
                begin
                    ctl_next = 1'b0;
                end
                else if (high)
                begin
                    if (gam_reg == 15'd256)
                    begin
                        again = 1'b0;
                        ph_next = (((bm_reg == 8'd0 ? b_reg : bb_reg) &
                                    (bm - 8'd1)) != 8'd0) ? zx0_pkg::PH_BAD
                                                          : zx0_pkg::PH_DONE;
                    end
                    else
                    begin
                        ph_next = zx0_pkg::PH_OFS_LOW;
                    end
                end
                else if (ph_reg == zx0_pkg::PH_LIT_LEN)
                begin
                    if (16'(gam_reg) > room)
                    begin
                        ph_next = zx0_pkg::PH_BAD; again = 1'b0;
                    end
                    else
                    begin
                        lit_next = gam_reg; ph_next = zx0_pkg::PH_LITERALS;
                    end
                end
                else
                begin
                    len = 16'(gam_reg) + ((ph_reg == zx0_pkg::PH_MATCH_LEN) ? 16'd1 : 16'd0);
                    if (ofs_reg == 15'd0 || 16'(ofs_reg) > 16'(wc_reg) || len > room)
                    begin
                        ph_next = zx0_pkg::PH_BAD;
                    end
                    else
                    begin
                        cop_next = len[14:0]; ph_next = zx0_pkg::PH_COPY;
                    end
                end
            end
        end
        if (cmd.start)
        begin
            emit_next = 1'b0; have_next = 1'b0; act_next = 1'b0;
            if (cmd.op == zx0_pkg::OP_RESTART)
            begin
                wc_next = '0; lit_next = '0; cop_next = '0; ofs_next = 15'd1;
                bb_next = '0; bm_next = '0; gam_next = 15'd1; ctl_next = 1'b1;
                ph_next = zx0_pkg::PH_LIT_LEN;
            end
            else if (cmd.op == zx0_pkg::OP_ADVANCE)
            begin
                act_next = 1'b1;
            end
            else if (cmd.op == zx0_pkg::OP_FEED)
            begin
                if (ph_reg == zx0_pkg::PH_DONE || ph_reg == zx0_pkg::PH_BAD)
                begin
                    ph_next = zx0_pkg::PH_BAD;
                end
                else if (waiting)
                begin
                    have_next = 1'b1;
                    act_next = 1'b1;
                end
            end
        end
    end

    assign stat.again = again;
    assign stat.read_wait = rd_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= 15'd16384;
            wc_reg <= '0; lit_reg <= '0; cop_reg <= '0; ofs_reg <= 15'd1;
            gam_reg <= 15'd1; ctl_reg <= 1'b1; bb_reg <= '0; bm_reg <= '0;
            ph_reg <= zx0_pkg::PH_LIT_LEN; have_reg <= 1'b0; emit_reg <= 1'b0;
            act_reg <= 1'b0;
            rd_reg <= 1'b0; res_out_valid <= 1'b0; res_need_byte <= 1'b0;
            res_status <= zx0_pkg::ST_RUN;
        end
        else
        begin
            if (cfg_we)
            begin
                capacity_reg <= cfg_data;
            end
            wc_reg <= wc_next; lit_reg <= lit_next; cop_reg <= cop_next;
            ofs_reg <= ofs_next; gam_reg <= gam_next; ctl_reg <= ctl_next;
            bb_reg <= bb_next; bm_reg <= bm_next; ph_reg <= ph_next;
            have_reg <= have_next; emit_reg <= emit_next; rd_reg <= rd_next;
            act_reg <= act_next;
            if (cmd.finish)
            begin
                res_out_valid <= emit_reg;
                res_need_byte <= waiting;
                res_status <= (ph_reg == zx0_pkg::PH_BAD) ? zx0_pkg::ST_ERR :
                              (ph_reg == zx0_pkg::PH_DONE) ? zx0_pkg::ST_DONE
                                                           : zx0_pkg::ST_RUN;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            b_reg <= cmd.data;
        end
        eaddr_reg <= eaddr_next;
        edata_reg <= edata_next;
        if (cmd.finish)
        begin
            res_out_addr <= emit_reg ? 14'(eaddr_reg) : 14'd0;
            res_out_data <= emit_reg ? edata_reg : 8'd0;
        end
    end
endmodule

// ===== hw/rtl/zx0_ctrl.sv =====
// Controller of the ZX0 decompressor: sequences accept, decode steps and
// result delivery. Depends on zx0_pkg.
module zx0_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [1:0]     in_opcode,
    input  logic [7:0]     in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output zx0_pkg::cmd_t  cmd,
    input  zx0_pkg::stat_t stat
);
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_STEP = 4'b0010,
        S_FIN  = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign accept = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE) || (state_reg == S_OUT && out_ready);
    assign out_valid = state_reg == S_OUT;

    always_comb
    begin
        cmd.start = accept;
        cmd.op = in_opcode;
        cmd.data = in_data;
        cmd.step = state_reg == S_STEP;
        cmd.finish = state_reg == S_FIN;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: state_next = accept ? S_STEP : S_IDLE;
            S_STEP: state_next = (stat.again || stat.read_wait) ? S_STEP : S_FIN;
            S_FIN:  state_next = S_OUT;
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = accept ? S_STEP : S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule

// ===== hw/rtl/zx0_stream_decompressor.sv =====
// Top level of the ZX0 v2 stream decompressor.
// Depends on zx0_pkg, zx0_if, zx0_ctrl, zx0_datapath and zx0_ram.
//
// Usage: each input word carries an opcode (feed a compressed byte, advance
// one step, restart) and a data byte. Each accepted word yields exactly one
// result word on the output channel: an optional decompressed byte with its
// output address, a need_byte flag telling the host that the next word should
// be a feed, and a sticky status (running, complete, error).
// The cfg channel writes the capacity register; write it only while the
// block is idle.
// Timing: after the accepting edge the controller runs one decode pass per
// cycle in S_STEP, registers the result in S_FIN and presents it in S_OUT.
// A pass handles one control bit, one literal or offset-low byte, or half
// of a copied byte (history read, then write); a pass that finds nothing
// left to do ends the word. A feed of a control byte may decode all eight
// of its bits and then copy a byte.
// Throughput: one word at a time; the next word is taken when the result
// leaves. The history lives in one single-port RAM, which sets the copy cost.
// Reset returns the decoder to the start of a stream with capacity 16384;
// history contents are undefined and are never read before being written.
// When the receiver stalls, the result is held and the next input word is
// taken in the same cycle the held result leaves.
module zx0_stream_decompressor (
    input logic clk,
    input logic rst_n,
    zx0_in_if.sink    in_ch,
    zx0_out_if.source out_ch,
    zx0_cfg_if.sink   cfg
);
    zx0_pkg::cmd_t  cmd;
    zx0_pkg::stat_t stat;

    // Configuration is always accepted.
    assign cfg.ready = 1'b1;

    zx0_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .in_opcode(in_ch.opcode), .in_data(in_ch.data_byte),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .cmd(cmd), .stat(stat));

    zx0_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .cfg_we(cfg.valid), .cfg_data(cfg.data),
        .res_out_valid(out_ch.out_valid), .res_out_addr(out_ch.out_addr),
        .res_out_data(out_ch.out_data), .res_need_byte(out_ch.need_byte),
        .res_status(out_ch.status));
endmodule

// ===== test/zx0_stream_checker.sv =====
// Checker for the ZX0 stream decompressor: watches the input, result and
// capacity channels, predicts every result word and compares it.
// Depends on zx0_pkg and the channel interfaces in zx0_if.
module zx0_stream_checker
    import zx0_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    zx0_in_if    in_ch,
    zx0_out_if   out_ch,
    zx0_cfg_if   cfg,
    output int   fail_count,
    output int   pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        out_valid;
        logic [13:0] out_addr;
        logic [7:0]  out_data;
        logic        need_byte;
        logic [1:0]  status;
    } result_t;

    result_t     expected_q[$];
    logic [7:0]  history [OUTPUT_DEPTH];
    int unsigned capacity;
    int unsigned written;
    int unsigned lit_left;
    int unsigned copy_left;
    int unsigned offset;
    int unsigned gamma;
    int unsigned ctl_byte;
    int unsigned ctl_mask;
    bit          want_ctl;
    logic [3:0]  phase;
    bit          emitted;
    logic [13:0] emit_addr;
    logic [7:0]  emit_data;

    assign pending_count = expected_q.size();

    function automatic int unsigned cap_limit();
        return (capacity > OUTPUT_DEPTH) ? OUTPUT_DEPTH : capacity;
    endfunction

    function automatic int unsigned room();
        return (written >= cap_limit()) ? 0 : cap_limit() - written;
    endfunction

    function automatic void begin_code(logic [3:0] next_phase);
        phase    = next_phase;
        gamma    = 1;
        want_ctl = 1'b1;
    endfunction

    function automatic void begin_copy(int unsigned length);
        if (offset == 0 || offset > written || length > room()) begin
            phase = PH_BAD;
            return;
        end
        copy_left = length;
        phase     = PH_COPY;
    endfunction

    function automatic void write_byte(logic [7:0] v);
        if (written >= OUTPUT_DEPTH) begin
            phase = PH_BAD;
            return;
        end
        history[written] = v;
        emitted   = 1'b1;
        emit_addr = written[13:0];
        emit_data = v;
        written++;
    endfunction

    function automatic void new_stream();
        written   = 0;
        lit_left  = 0;
        copy_left = 0;
        offset    = 1;
        ctl_byte  = 0;
        ctl_mask  = 0;
        begin_code(PH_LIT_LEN);
    endfunction

    function automatic bit waits_for_byte();
        if (phase == PH_DONE || phase == PH_BAD || phase == PH_COPY)
            return 1'b0;
        return phase == PH_LITERALS || phase == PH_OFS_LOW || ctl_mask == 0;
    endfunction

    // Runs the decoder until it produces a byte, needs a byte or stops.
    function automatic void decode(input bit have, input logic [7:0] b);
        bit          cbit;
        bit          high;
        int unsigned lim;
        int unsigned nxt;
        forever begin
            if (phase == PH_DONE || phase == PH_BAD)
                return;
            if (phase == PH_COPY) begin
                if (offset == 0 || offset > written) begin
                    phase = PH_BAD;
                    return;
                end
                write_byte(history[written - offset]);
                if (phase == PH_BAD)
                    return;
                copy_left--;
                if (copy_left == 0)
                    phase = PH_AFTER_MATCH;
                return;
            end
            if (phase == PH_LITERALS || phase == PH_OFS_LOW) begin
                if (!have)
                    return;
                have = 1'b0;
                if (phase == PH_LITERALS) begin
                    write_byte(b);
                    if (phase == PH_BAD)
                        return;
                    if (lit_left > 0)
                        lit_left--;
                    if (lit_left == 0)
                        phase = PH_AFTER_LIT;
                    return;
                end
                offset = gamma * 128 - (b >> 1);
                begin_code(PH_MATCH_LEN);
                if (b[0])
                    begin_copy(2);
                else
                    want_ctl = 1'b0;
                continue;
            end
            if (ctl_mask == 0) begin
                if (!have)
                    return;
                have     = 1'b0;
                ctl_byte = b;
                ctl_mask = 8'h80;
            end
            cbit     = (ctl_byte & ctl_mask) != 0;
            high     = phase == PH_OFS_HIGH;
            ctl_mask = ctl_mask >> 1;
            if (phase == PH_AFTER_LIT) begin
                begin_code(cbit ? PH_OFS_HIGH : PH_LAST_LEN);
            end else if (phase == PH_AFTER_MATCH) begin
                begin_code(cbit ? PH_OFS_HIGH : PH_LIT_LEN);
            end else if (!want_ctl) begin
                lim = high ? 256 : cap_limit();
                nxt = (gamma << 1) | (cbit ^ high);
                if (nxt > lim) begin
                    phase = PH_BAD;
                    return;
                end
                gamma    = nxt;
                want_ctl = 1'b1;
            end else if (!cbit) begin
                want_ctl = 1'b0;
            end else if (high) begin
                if (gamma == 256) begin
                    if (ctl_mask != 0 && (ctl_byte & ((ctl_mask << 1) - 1)) != 0)
                        phase = PH_BAD;
                    else
                        phase = PH_DONE;
                    return;
                end
                phase = PH_OFS_LOW;
            end else if (phase == PH_LIT_LEN) begin
                if (gamma > room()) begin
                    phase = PH_BAD;
                    return;
                end
                lit_left = gamma;
                phase    = PH_LITERALS;
            end else begin
                begin_copy(gamma + ((phase == PH_MATCH_LEN) ? 1 : 0));
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        result_t got;
        result_t want;
        if (!rst_n) begin
            capacity   = 16384;
            fail_count = 0;
            new_stream();
            expected_q.delete();
        end else begin
            if (cfg.valid && cfg.ready)
                capacity = cfg.data;
            if (out_ch.valid && out_ch.ready) begin
                got = '{out_ch.out_valid, out_ch.out_addr, out_ch.out_data,
                        out_ch.need_byte, out_ch.status};
                if (expected_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: result word with none expected, actual %h", $time, got);
                end else begin
                    want = expected_q.pop_front();
                    if (got.out_valid !== want.out_valid || got.out_addr !== want.out_addr
                        || got.out_data !== want.out_data
                        || got.need_byte !== want.need_byte
                        || got.status !== want.status) begin
                        fail_count++;
                        $display("%0t: mismatch expected v=%b a=%h d=%h n=%b s=%0d",
                                 $time, want.out_valid, want.out_addr, want.out_data,
                                 want.need_byte, want.status);
                        $display("%0t:          actual   v=%b a=%h d=%h n=%b s=%0d",
                                 $time, got.out_valid, got.out_addr, got.out_data,
                                 got.need_byte, got.status);
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                emitted   = 1'b0;
                emit_addr = '0;
                emit_data = '0;
                case (in_ch.opcode)
                    OP_FEED: begin
                        if (phase == PH_DONE || phase == PH_BAD)
                            phase = PH_BAD;
                        else if (waits_for_byte())
                            decode(1'b1, in_ch.data_byte);
                    end
                    OP_ADVANCE: decode(1'b0, 8'h00);
                    OP_RESTART: new_stream();
                    default: ;
                endcase
                want.out_valid = emitted;
                want.out_addr  = emit_addr;
                want.out_data  = emit_data;
                want.need_byte = waits_for_byte();
                want.status    = (phase == PH_BAD) ? ST_ERR
                               : ((phase == PH_DONE) ? ST_DONE : ST_RUN);
                expected_q.push_back(want);
            end
        end
    end

endmodule

// ===== test/tb_zx0_stream_decompressor.sv =====
// Top of the ZX0 stream decompressor testbench: clock, reset, stimulus and
// verdict. Depends on zx0_pkg, zx0_if, zx0_stream_checker and the block.
module tb_zx0_stream_decompressor;
    import zx0_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // The spare opcode, which the block must treat as a no-op.
    localparam logic [1:0] OP_NOP = 2'd3;
    localparam int CYCLE_LIMIT = 600000;

    // Deliberate defects that a generated stream may carry.
    typedef enum int {
        FLAW_NONE,
        FLAW_BAD_OFFSET,
        FLAW_PADDING,
        FLAW_OFS_HIGH,
        FLAW_BIT_FLIP,
        FLAW_TRUNCATE
    } flaw_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    zx0_in_if  in_ch ();
    zx0_out_if out_ch ();
    zx0_cfg_if cfg ();

    int fail_count;
    int pending_count;

    zx0_stream_decompressor dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg)
    );

    zx0_stream_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_ch         (in_ch),
        .out_ch        (out_ch),
        .cfg           (cfg),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always #5 clk = ~clk;

    // Words sent and result words received, plus the flags of the newest
    // result, which steer whether the next word is a feed or an advance.
    int         words_sent = 0;
    int         words_back = 0;
    int         streams_done = 0;
    int         cycles = 0;
    logic       last_need = 1'b0;
    logic [1:0] last_status = ST_RUN;
    bit         calm = 1'b0;       // no idling on either side
    bit         hold_req = 1'b0;   // ask the receiver for a long hold-off

    // Compressed stream under construction. Control bits go into the byte
    // that was opened last; a new control byte is appended only when the
    // current one is used up, which is the order the decoder reads them.
    logic [7:0]  stream_q[$];
    int          ctl_idx;
    logic [7:0]  ctl_mask;
    bit          gbits[$];

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("zx0_stream_decompressor verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (out_ch.valid && out_ch.ready)
        begin
            words_back++;
            last_need   = out_ch.need_byte;
            last_status = out_ch.status;
        end
    end

    // Receiver: random ready bursts, a long hold-off on request, and a
    // steady ready once the run goes calm.
    initial
    begin
        int n;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                for (int i = 0; i < 400; i++)
                begin
                    @(negedge clk);
                    out_ch.ready <= 1'b0;
                end
                hold_req = 1'b0;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                n = $urandom_range(1, 17);
                repeat (n)
                begin
                    @(negedge clk);
                    out_ch.ready <= 1'b0;
                end
            end
            else
            begin
                n = $urandom_range(1, 20);
                repeat (n)
                begin
                    @(negedge clk);
                    out_ch.ready <= 1'b1;
                end
            end
        end
    end

    // Offers one word and returns at the rising edge where it is taken.
    // The sender may first idle for a random burst, which is the only place
    // valid drops while words keep flowing.
    task automatic send_word(input logic [1:0] op, input logic [7:0] d);
        int gap;
        @(negedge clk);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 17);
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.opcode    <= op;
        in_ch.data_byte <= d;
        do @(posedge clk); while (!in_ch.ready);
        words_sent++;
    endtask

    // Drops valid and waits until every word sent has its result back.
    task automatic drain();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (words_back < words_sent) @(negedge clk);
    endtask

    // A result can be outstanding inside the block only as long as its
    // latency, so a short pause after draining makes the block idle.
    task automatic set_capacity(input logic [14:0] value);
        drain();
        repeat (16) @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.data  <= value;
        do @(posedge clk); while (!cfg.ready);
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    function automatic void put_bit(bit b);
        if (ctl_mask == 8'h00)
        begin
            stream_q.push_back(8'h00);
            ctl_idx  = stream_q.size() - 1;
            ctl_mask = 8'h80;
        end
        if (b)
            stream_q[ctl_idx] = stream_q[ctl_idx] | ctl_mask;
        ctl_mask = ctl_mask >> 1;
    endfunction

    // Interlaced Elias-gamma: for each bit below the leading one, a zero
    // control bit and the data bit; a one control bit ends the code. The
    // offset-high code stores its data bits inverted.
    function automatic void gamma_code(int unsigned n, bit invert);
        int top;
        gbits.delete();
        top = 0;
        for (int i = 0; i < 32; i++)
            if (n[i])
                top = i;
        for (int i = top - 1; i >= 0; i--)
        begin
            gbits.push_back(1'b0);
            gbits.push_back(n[i] ^ invert);
        end
        gbits.push_back(1'b1);
    endfunction

    function automatic void put_gamma(int unsigned n, bit invert);
        gamma_code(n, invert);
        foreach (gbits[i])
            put_bit(gbits[i]);
    endfunction

    // Builds one compressed stream: a literal run first, then a few
    // matches and literal runs, then the end marker. Short runs keep the
    // number of advance words per stream down; a rare long run lets
    // offsets go past one 128-byte step of the offset-high code.
    function automatic void build_stream(flaw_t flaw, int tokens);
        int          produced;
        int          nlit;
        int unsigned ofs;
        int unsigned hi;
        int unsigned len;
        bit          after_lit;
        bit          take_new;
        stream_q.delete();
        ctl_mask  = 8'h00;
        nlit      = ($urandom_range(0, 9) == 0) ? $urandom_range(130, 200)
                                                 : $urandom_range(1, 6);
        put_gamma(nlit, 1'b0);
        repeat (nlit) stream_q.push_back($urandom_range(0, 255));
        produced  = nlit;
        after_lit = 1'b1;
        for (int t = 0; t < tokens; t++)
        begin
            take_new = (flaw == FLAW_BAD_OFFSET && t == 0) || $urandom_range(0, 1);
            if (take_new)
            begin
                // Match with a new offset; the low byte's bit zero is the
                // first control bit of the length code.
                put_bit(1'b1);
                ofs = (flaw == FLAW_BAD_OFFSET && t == 0) ? produced + 1
                                                          : $urandom_range(1, produced);
                hi  = (ofs + 127) / 128;
                put_gamma(hi, 1'b1);
                len = $urandom_range(2, 8);
                gamma_code(len - 1, 1'b0);
                stream_q.push_back(8'(((hi * 128 - ofs) << 1) | gbits[0]));
                for (int i = 1; i < gbits.size(); i++)
                    put_bit(gbits[i]);
                produced += len;
                after_lit = 1'b0;
            end
            else if (after_lit)
            begin
                // Match that repeats the last offset.
                put_bit(1'b0);
                len = $urandom_range(1, 8);
                put_gamma(len, 1'b0);
                produced += len;
                after_lit = 1'b0;
            end
            else
            begin
                put_bit(1'b0);
                nlit = $urandom_range(1, 6);
                put_gamma(nlit, 1'b0);
                repeat (nlit) stream_q.push_back($urandom_range(0, 255));
                produced += nlit;
                after_lit = 1'b1;
            end
        end
        // End marker: offset-high value 256, or above the cap when the
        // stream is meant to fail there.
        put_bit(1'b1);
        put_gamma((flaw == FLAW_OFS_HIGH) ? 300 : 256, 1'b1);
        if (flaw == FLAW_PADDING && ctl_mask != 8'h00)
            stream_q[ctl_idx] = stream_q[ctl_idx] | ctl_mask;
        if (flaw == FLAW_BIT_FLIP)
        begin
            int k;
            k = $urandom_range(0, stream_q.size() - 1);
            stream_q[k] = stream_q[k] ^ (8'h01 << $urandom_range(0, 7));
        end
        if (flaw == FLAW_TRUNCATE)
            stream_q = stream_q[0:$urandom_range(0, stream_q.size() - 1)];
    endfunction

    // Plays a stream word by word, choosing feed or advance from the flags
    // of the previous result. A little noise is mixed in: advances and feeds
    // of random bytes at any point, spare opcodes, and words after the
    // stream has ended.
    task automatic play_stream(flaw_t flaw, int tokens);
        int pos;
        build_stream(flaw, tokens);
        send_word(OP_RESTART, $urandom_range(0, 255));
        drain();
        pos = 0;
        while (last_status == ST_RUN)
        begin
            case ($urandom_range(0, 19))
                0: send_word(OP_ADVANCE, $urandom_range(0, 255));
                1: send_word(OP_NOP, $urandom_range(0, 255));
                2: send_word(OP_FEED, $urandom_range(0, 255));
                default:
                begin
                    if (!last_need)
                        send_word(OP_ADVANCE, $urandom_range(0, 255));
                    else if (pos < stream_q.size())
                        send_word(OP_FEED, stream_q[pos++]);
                    else
                        break;
                end
            endcase
            drain();
        end
        if ($urandom_range(0, 2) == 0)
            send_word($urandom_range(0, 1) ? OP_FEED : OP_ADVANCE, $urandom_range(0, 255));
        streams_done++;
    endtask

    // Random words without waiting for results.
    task automatic send_noise(int count);
        repeat (count) send_word($urandom_range(0, 3), $urandom_range(0, 255));
    endtask

    task automatic random_phase(int budget);
        int   roll;
        flaw_t flaw;
        while (words_sent < budget)
        begin
            roll = $urandom_range(0, 19);
            if (roll == 0)
            begin
                send_noise($urandom_range(5, 20));
            end
            else
            begin
                case (roll)
                    1: flaw = FLAW_BIT_FLIP;
                    2: flaw = FLAW_TRUNCATE;
                    3: flaw = FLAW_PADDING;
                    4: flaw = FLAW_BAD_OFFSET;
                    5: flaw = FLAW_OFS_HIGH;
                    default: flaw = FLAW_NONE;
                endcase
                play_stream(flaw, $urandom_range(1, 6));
            end
        end
    endtask

    initial
    begin
        in_ch.valid     = 1'b0;
        in_ch.opcode    = OP_FEED;
        in_ch.data_byte = 8'h00;
        cfg.valid       = 1'b0;
        cfg.data        = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // Directed part: idle opcodes straight after reset, one small clean
        // stream, then one stream for each of three failure kinds: a bad
        // offset, nonzero end padding and an offset-high code above 256.
        send_word(OP_NOP, 8'hFF);
        send_word(OP_ADVANCE, 8'h00);
        drain();
        play_stream(FLAW_NONE, 1);
        play_stream(FLAW_BAD_OFFSET, 1);
        play_stream(FLAW_PADDING, 1);
        play_stream(FLAW_OFS_HIGH, 1);
        // A feed after an error keeps the error; an advance does nothing.
        send_word(OP_FEED, 8'h00);
        send_word(OP_ADVANCE, 8'h00);

        // Zero capacity fails on the first literal run, small capacities
        // fail partway, and the largest register value acts as the depth.
        set_capacity(15'd0);
        play_stream(FLAW_NONE, 2);
        set_capacity(15'h7FFF);
        random_phase(370);
        set_capacity(15'd12);
        random_phase(500);
        set_capacity(15'($urandom_range(20, 60)));
        random_phase(650);

        // Long receiver hold-off while the sender keeps offering words, so
        // the block fills up and stalls its input.
        set_capacity(15'd16384);
        hold_req = 1'b1;
        send_word(OP_RESTART, 8'h00);
        send_noise(60);
        drain();
        random_phase(1200);

        // Last part without idling on either side.
        calm = 1'b1;
        set_capacity(15'($urandom_range(100, 16384)));
        random_phase(1420);

        drain();
        repeat (20) @(negedge clk);
        $display("run covered %0d streams in %0d words over %0d cycles,",
                 streams_done, words_sent, cycles);
        $display("with capacity changes, corrupted streams and a long output stall");
        if (fail_count == 0 && pending_count == 0 && words_back == words_sent)
            $display("zx0_stream_decompressor verification clean");
        else
            $display("zx0_stream_decompressor verification failed");
        $finish;
    end

endmodule
